/* rtl/rrts_pkg.sv */
// Shared codes and controller/datapath interface types of the round-robin task scheduler.
package rrts_pkg;

    // Task slot status codes.
    localparam logic [2:0] ST_INVALID = 3'd0;
    localparam logic [2:0] ST_CREATED = 3'd1;
    localparam logic [2:0] ST_READY   = 3'd2;
    localparam logic [2:0] ST_WAITING = 3'd3;
    localparam logic [2:0] ST_EXITED  = 3'd4;

    // Item kind codes.
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_YIELD  = 3'd1;
    localparam logic [2:0] KIND_DELAY  = 3'd2;
    localparam logic [2:0] KIND_EXIT   = 3'd3;
    localparam logic [2:0] KIND_CREATE = 3'd4;

    // Slot index register update selects.
    localparam logic [1:0] IDX_HOLD     = 2'd0;
    localparam logic [1:0] IDX_ZERO     = 2'd1;
    localparam logic [1:0] IDX_INC      = 2'd2;
    localparam logic [1:0] IDX_CUR_NEXT = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       latch;
        logic       exec;
        logic [1:0] idx_sel;
        logic       rd_en;
        logic       tick_proc;
        logic       search_proc;
        logic       load_out;
    } rrts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] kind;
        logic       tick_last;
        logic       hit;
        logic       miss_end;
    } rrts_sts_t;

endpackage

/* rtl/rrts_dp.sv */
// Datapath of the task scheduler: slot tables, current task, free slot and result registers.
module rrts_dp #(
    parameter int MAX_TASKS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         kind,
    input  logic [15:0]        delay_ticks,
    input  logic [15:0]        stack_bytes,
    input  rrts_pkg::rrts_cmd_t cmd,
    output rrts_pkg::rrts_sts_t sts,
    output logic [2:0]         running_task,
    output logic               switched,
    output logic               first_run,
    output logic [2:0]         created_slot,
    output logic               failed
);
    import rrts_pkg::*;

    localparam int TW = $clog2(MAX_TASKS);
    localparam int FW = $clog2(MAX_TASKS + 1);
    localparam logic [TW-1:0] LAST_IDX = TW'(MAX_TASKS - 1);
    localparam logic [FW-1:0] FULL     = FW'(MAX_TASKS);

    function automatic logic [TW-1:0] next_idx(input logic [TW-1:0] v);
        next_idx = (v == LAST_IDX) ? '0 : v + 1'b1;
    endfunction

    // Latched item.
    logic [2:0]  kind_reg;
    logic [15:0] dly_reg;
    logic [15:0] stk_reg;

    // Control state.
    logic [TW-1:0]        cur_reg;
    logic [FW-1:0]        free_reg;
    logic [TW-1:0]        idx_reg;
    logic [TW-1:0]        idx_next;
    logic [MAX_TASKS-1:0] vld_reg;

    // Tables and their registered read data.
    logic [2:0]    status_mem [MAX_TASKS];
    logic [15:0]   wait_mem   [MAX_TASKS];
    logic [2:0]    rd_st_reg;
    logic [15:0]   rd_wc_reg;
    logic          rd_vld_reg;
    logic [TW-1:0] rd_idx_reg;

    // Per-item flags.
    logic          sw_reg;
    logic          first_reg;
    logic          fail_reg;
    logic [TW-1:0] made_reg;

    logic [2:0]    rd_st;
    logic [15:0]   wc_dec;
    logic          hit;
    logic          create_ok;
    logic          st_we;
    logic [TW-1:0] st_waddr;
    logic [2:0]    st_wdata;
    logic          wc_we;
    logic [TW-1:0] wc_waddr;
    logic [15:0]   wc_wdata;

    assign rd_st     = rd_vld_reg ? rd_st_reg : ST_INVALID;
    assign wc_dec    = (rd_wc_reg == 16'd0) ? 16'd0 : rd_wc_reg - 16'd1;
    assign hit       = (rd_st == ST_CREATED) || (rd_st == ST_READY);
    assign create_ok = (kind_reg == KIND_CREATE) && (stk_reg != 16'd0) && (free_reg < FULL);

    assign sts.kind      = kind_reg;
    assign sts.tick_last = (rd_idx_reg == LAST_IDX);
    assign sts.hit       = hit;
    assign sts.miss_end  = (next_idx(rd_idx_reg) == cur_reg);

    // Single write port of each table; only one source is active in a cycle.
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = cur_reg;
        st_wdata = ST_INVALID;
        wc_we    = 1'b0;
        wc_waddr = cur_reg;
        wc_wdata = dly_reg;
        if (cmd.exec)
        begin
            case (kind_reg)
                KIND_DELAY:
                begin
                    st_we    = 1'b1;
                    st_wdata = ST_WAITING;
                    wc_we    = 1'b1;
                end
                KIND_EXIT:
                begin
                    st_we    = 1'b1;
                    st_wdata = ST_EXITED;
                end
                KIND_CREATE:
                begin
                    if (create_ok)
                    begin
                        st_we    = 1'b1;
                        st_waddr = free_reg[TW-1:0];
                        st_wdata = ST_CREATED;
                        wc_we    = 1'b1;
                        wc_waddr = free_reg[TW-1:0];
                        wc_wdata = 16'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.tick_proc && (rd_st == ST_WAITING))
        begin
            wc_we    = 1'b1;
            wc_waddr = rd_idx_reg;
            wc_wdata = wc_dec;
            if (wc_dec == 16'd0)
            begin
                st_we    = 1'b1;
                st_waddr = rd_idx_reg;
                st_wdata = ST_READY;
            end
        end
        if (cmd.search_proc)
        begin
            if (hit)
            begin
                st_we    = 1'b1;
                st_waddr = rd_idx_reg;
                st_wdata = ST_READY;
            end
            else if (rd_st == ST_EXITED)
            begin
                st_we    = 1'b1;
                st_waddr = rd_idx_reg;
                st_wdata = ST_INVALID;
            end
        end
    end

    always_comb
    begin
        case (cmd.idx_sel)
            IDX_HOLD:     idx_next = idx_reg;
            IDX_ZERO:     idx_next = '0;
            IDX_INC:      idx_next = next_idx(idx_reg);
            IDX_CUR_NEXT: idx_next = next_idx(cur_reg);
            default:      idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            status_mem[st_waddr] <= st_wdata;
        end
        if (wc_we)
        begin
            wait_mem[wc_waddr] <= wc_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_st_reg  <= status_mem[idx_reg];
            rd_wc_reg  <= wait_mem[idx_reg];
            rd_vld_reg <= vld_reg[idx_reg];
            rd_idx_reg <= idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            cur_reg  <= '0;
            free_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (st_we)
            begin
                vld_reg[st_waddr] <= 1'b1;
            end
            if (cmd.search_proc && hit)
            begin
                cur_reg <= rd_idx_reg;
            end
            if (cmd.exec && create_ok)
            begin
                free_reg <= free_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= kind;
            dly_reg  <= delay_ticks;
            stk_reg  <= stack_bytes;
        end
        if (cmd.exec)
        begin
            sw_reg    <= 1'b0;
            first_reg <= 1'b0;
            fail_reg  <= (kind_reg == KIND_CREATE) && !create_ok;
            made_reg  <= create_ok ? free_reg[TW-1:0] : '0;
        end
        else if (cmd.search_proc && hit)
        begin
            sw_reg    <= 1'b1;
            first_reg <= (rd_st == ST_CREATED);
        end
        if (cmd.load_out)
        begin
            running_task <= 3'(cur_reg);
            switched     <= sw_reg;
            first_run    <= first_reg;
            created_slot <= 3'(made_reg);
            failed       <= fail_reg;
        end
    end

endmodule

/* rtl/rrts_ctrl.sv */
// Controller state machine of the task scheduler: sequences the sweeps and the handshakes.
module rrts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rrts_pkg::rrts_sts_t sts,
    output rrts_pkg::rrts_cmd_t cmd
);
    import rrts_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_EXEC       = 3'd1;
    localparam logic [2:0] S_TICK_FIRST = 3'd2;
    localparam logic [2:0] S_TICK_PROC  = 3'd3;
    localparam logic [2:0] S_SRCH_RD    = 3'd4;
    localparam logic [2:0] S_SRCH_CHK   = 3'd5;
    localparam logic [2:0] S_DONE       = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.idx_sel = IDX_HOLD;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                case (sts.kind)
                    KIND_TICK:
                    begin
                        cmd.idx_sel = IDX_ZERO;
                        state_next  = S_TICK_FIRST;
                    end
                    KIND_YIELD, KIND_DELAY, KIND_EXIT:
                    begin
                        cmd.idx_sel = IDX_CUR_NEXT;
                        state_next  = S_SRCH_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_TICK_FIRST:
            begin
                cmd.rd_en   = 1'b1;
                cmd.idx_sel = IDX_INC;
                state_next  = S_TICK_PROC;
            end
            S_TICK_PROC:
            begin
                cmd.tick_proc = 1'b1;
                if (sts.tick_last)
                begin
                    cmd.idx_sel = IDX_CUR_NEXT;
                    state_next  = S_SRCH_RD;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.idx_sel = IDX_INC;
                end
            end
            S_SRCH_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.idx_sel = IDX_INC;
                state_next  = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                cmd.search_proc = 1'b1;
                if (sts.hit || sts.miss_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.idx_sel = IDX_INC;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/round_robin_task_scheduler_core.sv */
// Top level of the round-robin task scheduler with tick delays.
//
// This block keeps a status and a delay count for each of MAX_TASKS task slots, together
// with the current task and the next free slot, and handles one input word at a time: a
// tick, a yield, a delay or an exit of the current task, or a create. A tick first sweeps
// all slots and counts down the waiting ones, making a slot ready when its count reaches
// zero; a tick, yield, delay or exit then searches round-robin from the slot after the
// current one for a created or ready task, freeing exited slots as it passes them. Each
// input word yields exactly one output word that reports the running task, whether it
// changed, whether it runs for the first time, and the outcome of a create. The slot
// tables are memories with one write and one registered read port, swept one slot per
// cycle with the next read overlapped with the current update. A create or an unknown
// kind skips the search; the search examines 1 to MAX_TASKS - 1 slots. The next input
// word is accepted as soon as the previous one has been moved into the output register,
// even while that output word still waits for out_ready. Slot status resets to invalid
// through per-slot valid flops, so no clearing pass is needed after reset.
module round_robin_task_scheduler_core #(
    parameter int MAX_TASKS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [15:0] delay_ticks,
    input  logic [15:0] stack_bytes,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  running_task,
    output logic        switched,
    output logic        first_run,
    output logic [2:0]  created_slot,
    output logic        failed
);
    import rrts_pkg::*;

    // Command and status groups between the controller and the datapath.
    rrts_cmd_t cmd;
    rrts_sts_t sts;

    // The controller owns the handshakes and the sweep sequencing.
    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the slot tables, the scheduler state and the output word.
    rrts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .kind         (kind),
        .delay_ticks  (delay_ticks),
        .stack_bytes  (stack_bytes),
        .cmd          (cmd),
        .sts          (sts),
        .running_task (running_task),
        .switched     (switched),
        .first_run    (first_run),
        .created_slot (created_slot),
        .failed       (failed)
    );

endmodule

/* tb/round_robin_task_scheduler_core_test.sv */
// Self-checking testbench for the round-robin task scheduler core.
module round_robin_task_scheduler_core_test;

    import rrts_pkg::*;

    // The scheduler is built with its default eight task slots.
    localparam int NUM_SLOTS = 8;

    // Kind codes past create are reserved; the block must ignore them.
    localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

    // Random stimulus length, counted in input words of any kind.
    localparam int ITEM_TARGET = 1950;

    // The receiver goes deaf once, for this many cycles, after this many input words.
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 300;

    // Allow a settling margin after the last expected word before the run is closed.
    localparam int SETTLE_CYCLES = 40;

    // The longest correct silence is the receiver hold-off plus one item; the watchdog
    // limit is taken well above that.
    localparam int WATCHDOG_LIMIT = 4000;

    // One output word of the scheduler.
    typedef struct packed {
        bit [2:0] running_task;
        bit       switched;
        bit       first_run;
        bit [2:0] created_slot;
        bit       failed;
    } sched_report_t;

    // Scoreboard: a cycle-free model of the slot table that turns each accepted input word
    // into the output word the block must produce, and checks those words in order.
    class scheduler_scoreboard;
        bit [2:0]      slot_state [NUM_SLOTS];
        bit [15:0]     ticks_left [NUM_SLOTS];
        int            cur_slot;
        int            next_free;
        sched_report_t pending_reports [$];

        int errors;
        int words_in;
        int words_out;
        int n_ticks;
        int n_switches;
        int n_first_runs;
        int n_no_runnable;
        int n_failed_creates;

        // Round-robin search from the slot after the current one. Exited slots passed on
        // the way are freed. Returns 1 when another task takes over.
        function bit advance_round_robin(output bit first);
            int  k;
            bit  found;
            first = 1'b0;
            found = 1'b0;
            k     = (cur_slot + 1) % NUM_SLOTS;
            while (k != cur_slot && !found)
            begin
                if (slot_state[k] == ST_CREATED || slot_state[k] == ST_READY)
                    found = 1'b1;
                else
                begin
                    if (slot_state[k] == ST_EXITED)
                        slot_state[k] = ST_INVALID;
                    k = (k + 1) % NUM_SLOTS;
                end
            end
            if (!found)
                return 1'b0;
            first         = (slot_state[k] == ST_CREATED);
            slot_state[k] = ST_READY;
            cur_slot      = k;
            return 1'b1;
        endfunction

        function void note_word(logic [2:0] k, logic [15:0] dly, logic [15:0] stk);
            sched_report_t r;
            bit            first;
            int            i;
            r        = '0;
            first    = 1'b0;
            words_in++;
            case (k)
                KIND_TICK:
                begin
                    n_ticks++;
                    for (i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (slot_state[i] == ST_WAITING)
                        begin
                            if (ticks_left[i] != 16'd0)
                                ticks_left[i] = ticks_left[i] - 16'd1;
                            if (ticks_left[i] == 16'd0)
                                slot_state[i] = ST_READY;
                        end
                    end
                    r.switched = advance_round_robin(first);
                end
                KIND_YIELD:
                begin
                    r.switched = advance_round_robin(first);
                end
                KIND_DELAY:
                begin
                    slot_state[cur_slot] = ST_WAITING;
                    ticks_left[cur_slot] = dly;
                    r.switched = advance_round_robin(first);
                end
                KIND_EXIT:
                begin
                    slot_state[cur_slot] = ST_EXITED;
                    r.switched = advance_round_robin(first);
                end
                KIND_CREATE:
                begin
                    if (stk == 16'd0 || next_free >= NUM_SLOTS)
                    begin
                        r.failed = 1'b1;
                        n_failed_creates++;
                    end
                    else
                    begin
                        r.created_slot        = next_free[2:0];
                        slot_state[next_free] = ST_CREATED;
                        ticks_left[next_free] = '0;
                        next_free++;
                    end
                end
                default: ;
            endcase
            r.first_run    = first;
            r.running_task = cur_slot[2:0];
            if (k <= KIND_EXIT && !r.switched)
                n_no_runnable++;
            n_switches   += int'(r.switched);
            n_first_runs += int'(r.first_run);
            pending_reports.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_word(logic [2:0] rt, logic sw, logic fr, logic [2:0] cs, logic fl);
            sched_report_t want;
            words_out++;
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t: output word with none expected, actual task %0d", $time, rt);
                return;
            end
            want = pending_reports.pop_front();
            compare_field("running_task", 16'(want.running_task), 16'(rt));
            compare_field("switched", 16'(want.switched), 16'(sw));
            compare_field("first_run", 16'(want.first_run), 16'(fr));
            compare_field("created_slot", 16'(want.created_slot), 16'(cs));
            compare_field("failed", 16'(want.failed), 16'(fl));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  kind;
    logic [15:0] delay_ticks;
    logic [15:0] stack_bytes;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  running_task;
    logic        switched;
    logic        first_run;
    logic [2:0]  created_slot;
    logic        failed;

    scheduler_scoreboard sb;
    int                  idle_cycles;

    round_robin_task_scheduler_core #(
        .MAX_TASKS(NUM_SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .delay_ticks(delay_ticks),
        .stack_bytes(stack_bytes),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .running_task(running_task),
        .switched(switched),
        .first_run(first_run),
        .created_slot(created_slot),
        .failed(failed)
    );

    always #10 clk = ~clk;

    // Monitor. Both channels are sampled at the rising edge, where the testbench drives
    // with nonblocking assignments and the block updates its registers, so every value
    // seen here is the one that was stable before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_word(kind, delay_ticks, stack_bytes);
            if (out_valid && out_ready)
                sb.check_word(running_task, switched, first_run, created_slot, failed);
        end
    end

    // Watchdog. Any handshake on either side proves progress; a long silence means the
    // block has hung or lost a word.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d words still expected",
                     $time, idle_cycles, sb.pending_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver. It alternates segments of full speed, light stalls and heavy stalls. Once,
    // part way into the random traffic, it stops taking words for a long stretch so that
    // the block fills its output register and has to push back on its input.
    initial
    begin : receiver
        int seg_len;
        int mode;
        int i;
        bit held;
        out_ready = 1'b0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && sb.words_in >= HOLD_OFF_AT)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                for (i = 0; i < HOLD_OFF_CYCLES; i++)
                    @(posedge clk);
            end
            else
            begin
                seg_len = $urandom_range(10, 80);
                mode    = $urandom_range(0, 3);
                for (i = 0; i < seg_len; i++)
                begin
                    case (mode)
                        0, 1:    out_ready <= 1'b1;
                        2:       out_ready <= ($urandom_range(0, 1) == 0);
                        default: out_ready <= ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Offers one word and holds it, unchanged, until the block takes it.
    task automatic send_word(input logic [2:0] k, input logic [15:0] dly, input logic [15:0] stk);
        in_valid    <= 1'b1;
        kind        <= k;
        delay_ticks <= dly;
        stack_bytes <= stk;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stops offering words and waits until every expected output word has arrived. The
    // first edge lets the monitor log the word accepted at the edge just passed.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_reports.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [2:0]  k;
        logic [15:0] dly;
        logic [15:0] stk;
        int          counted;
        int          burst;
        int          pick;
        int          u;
        bit          paused;

        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_YIELD;
        delay_ticks = '0;
        stack_bytes = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. On an empty table every search comes back to the current slot,
        // so nothing switches, and a delay or an exit leaves the current slot waiting or
        // exited. A zero delay makes the next tick wake the task.
        send_word(KIND_YIELD, 16'h0000, 16'h0000);
        send_word(KIND_TICK, 16'h0000, 16'h0000);
        send_word(KIND_DELAY, 16'h0000, 16'h0000);
        send_word(KIND_TICK, 16'hFFFF, 16'hFFFF);
        send_word(KIND_EXIT, 16'h0000, 16'h0000);

        // A create with no stack fails; then the first tasks are created. Slot zero is
        // current, so it only runs once the search has moved away from it.
        send_word(KIND_CREATE, 16'hFFFF, 16'h0000);
        send_word(KIND_CREATE, 16'h0000, 16'hFFFF);
        send_word(KIND_CREATE, 16'h0000, 16'h0001);
        send_word(KIND_YIELD, 16'h0000, 16'h0000);
        send_word(KIND_YIELD, 16'h0000, 16'h0000);
        send_word(KIND_CREATE, 16'h0000, 16'h8000);
        send_word(KIND_CREATE, 16'h0000, 16'(($urandom_range(1, 16'hFFFE))));

        // Zero delay waits for exactly one tick; a full-scale delay parks a task for good.
        // The exit leaves a slot that the next pass over it frees.
        send_word(KIND_DELAY, 16'h0000, 16'h0000);
        send_word(KIND_TICK, 16'h0000, 16'h0000);
        send_word(KIND_DELAY, 16'hFFFF, 16'h0000);
        send_word(KIND_EXIT, 16'h0000, 16'h0000);
        send_word(KIND_YIELD, 16'h0000, 16'h0000);
        send_word(KIND_YIELD, 16'h0000, 16'h0000);

        // Reserved kinds change nothing.
        for (u = KIND_UNUSED_FIRST; u <= KIND_UNUSED_LAST; u++)
            send_word(3'(u), 16'($urandom), 16'($urandom));

        // Fill the rest of the table, then a create that finds it full.
        repeat (NUM_SLOTS - 4)
            send_word(KIND_CREATE, 16'($urandom), 16'($urandom_range(1, 16'hFFFF)));
        send_word(KIND_CREATE, 16'h0000, 16'hFFFF);

        drain_results();

        // Random part. Ticks, yields and delays dominate so the tasks keep cycling through
        // ready and waiting; exits are rare so the table stays populated for most of the
        // run. Delays are mostly short, with an occasional full-width value.
        counted = 0;
        paused  = 1'b0;
        while (counted < ITEM_TARGET)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                pick = $urandom_range(0, 999);
                dly  = ($urandom_range(0, 199) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
                stk  = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
                if (pick < 350)
                    k = KIND_TICK;
                else if (pick < 570)
                    k = KIND_YIELD;
                else if (pick < 880)
                    k = KIND_DELAY;
                else if (pick < 884)
                    k = KIND_EXIT;
                else if (pick < 950)
                    k = KIND_CREATE;
                else
                    k = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
                send_word(k, dly, stk);
                counted++;
            end

            // Halfway through, the sender waits once for the block to empty completely.
            // Otherwise most bursts end in a short random gap, some run straight on.
            if (!paused && counted >= ITEM_TARGET / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d input words and %0d output words: %0d ticks, %0d task switches,",
                 sb.words_in, sb.words_out, sb.n_ticks, sb.n_switches);
        $display("%0d first runs, %0d searches with no runnable task, %0d failed creates.",
                 sb.n_first_runs, sb.n_no_runnable, sb.n_failed_creates);
        if (sb.errors == 0 && sb.pending_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
